// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the generator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tf_pkg.sv =====
// Package for the Threefry-2x32 generator: pipeline stage type, constants, rotate.
// No dependencies.
package tf_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_GROUPS = 5;
    localparam int unsigned NUM_ROUNDS = 4;
    // One entry stage, then four round stages and one key injection per group.
    localparam int unsigned NUM_STAGES = 1 + NUM_GROUPS * (NUM_ROUNDS + 1);

    localparam logic [WORD_W-1:0] PARITY_WORD = 32'h1BD1_1BDA;

    localparam logic [4:0] ROT_EVEN [NUM_ROUNDS] = '{5'd13, 5'd15, 5'd26, 5'd6};
    localparam logic [4:0] ROT_ODD  [NUM_ROUNDS] = '{5'd17, 5'd29, 5'd16, 5'd24};

    typedef struct packed {
        logic [2:0][WORD_W-1:0] kw;
        logic [WORD_W-1:0]      a;
        logic [WORD_W-1:0]      b;
        logic                   last;
    } tf_stage_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] d);
        logic [5:0] rd;
        begin
            rd = 6'd32 - {1'b0, d};
            rotl32 = (v << d) | (v >> rd);
        end
    endfunction

endpackage

// ===== hw/rtl/tf_if.sv =====
// Channel interfaces for the generator: counter/key requests in, random words out.
// Depends on tf_pkg for the word width.
interface tf_in_if;
    import tf_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] key_lo;
    logic [WORD_W-1:0] key_hi;
    logic [WORD_W-1:0] count_lo;
    logic [WORD_W-1:0] count_hi;
    logic              last_in;

    modport source (output valid, key_lo, key_hi, count_lo, count_hi, last_in,
                    input ready);
    modport sink   (input valid, key_lo, key_hi, count_lo, count_hi, last_in,
                    output ready);
endinterface

interface tf_out_if;
    import tf_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] rand_lo;
    logic [WORD_W-1:0] rand_hi;
    logic              last_out;

    modport source (output valid, rand_lo, rand_hi, last_out, input ready);
    modport sink   (input valid, rand_lo, rand_hi, last_out, output ready);
endinterface

// ===== hw/rtl/threefry2x32_20_round_generator.sv =====
// Channel   Dir   Payload                                   Handshake
// cnt       in    key_lo, key_hi, count_lo, count_hi, last  valid / ready
// rnd       out   rand_lo, rand_hi, last_out                valid / ready
//
// A request enters every cycle while the output is not stalled; its result passes
// through one entry stage, twenty round stages and five key injection stages.
// Reset clears only the valid bits of the stages.
// When the output holds a result that is not taken, the whole pipeline holds
// and cnt.ready drops; nothing is lost or repeated.
// Depends on tf_pkg, tf_if, tf_round, tf_inject and assert_macros.svh.
`include "assert_macros.svh"

module threefry2x32_20_round_generator (
    input logic clk,
    input logic rst_n,
    tf_in_if.sink    cnt,
    tf_out_if.source rnd
);
    import tf_pkg::*;

    logic                      en;
    logic [NUM_STAGES-1:0]     vld;
    tf_stage_t                 dat [NUM_STAGES];

    logic      entry_valid_reg;
    tf_stage_t entry_reg;
    tf_stage_t entry_next;

    assign en        = !vld[NUM_STAGES-1] || rnd.ready;
    assign cnt.ready = en;

    always_comb
    begin
        entry_next.kw[0] = cnt.key_lo;
        entry_next.kw[1] = cnt.key_hi;
        entry_next.kw[2] = cnt.key_lo ^ cnt.key_hi ^ PARITY_WORD;
        entry_next.a     = cnt.count_lo + cnt.key_lo;
        entry_next.b     = cnt.count_hi + cnt.key_hi;
        entry_next.last  = cnt.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= cnt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign vld[0] = entry_valid_reg;
    assign dat[0] = entry_reg;

    for (genvar g = 1; g <= NUM_GROUPS; g++)
    begin : g_group
        localparam int unsigned BASE = (g - 1) * (NUM_ROUNDS + 1);

        for (genvar r = 0; r < NUM_ROUNDS; r++)
        begin : g_round
            localparam logic [4:0] ROT = (g % 2 == 1) ? ROT_EVEN[r] : ROT_ODD[r];

            tf_round #(
                .ROT (ROT)
            ) u_round (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid   (vld[BASE + r]),
                .data    (dat[BASE + r]),
                .valid_q (vld[BASE + r + 1]),
                .data_q  (dat[BASE + r + 1])
            );
        end

        tf_inject #(
            .GROUP (g)
        ) u_inject (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid   (vld[BASE + NUM_ROUNDS]),
            .data    (dat[BASE + NUM_ROUNDS]),
            .valid_q (vld[BASE + NUM_ROUNDS + 1]),
            .data_q  (dat[BASE + NUM_ROUNDS + 1])
        );
    end

    assign rnd.valid    = vld[NUM_STAGES-1];
    assign rnd.rand_lo  = dat[NUM_STAGES-1].a;
    assign rnd.rand_hi  = dat[NUM_STAGES-1].b;
    assign rnd.last_out = dat[NUM_STAGES-1].last;

    `ASSERT_NEXT(a_entry_fill, clk, rst_n, cnt.valid && cnt.ready, vld[0])
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !en, $stable(vld))
    `ASSERT_IMPLIES(a_backpressure, clk, rst_n, rnd.valid && !rnd.ready, !cnt.ready)

endmodule

// ===== hw/rtl/tf_round.sv =====
// One add-rotate-xor round as a pipeline register stage.
// Depends on tf_pkg.
module tf_round #(
    parameter logic [4:0] ROT = tf_pkg::ROT_EVEN[0]
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  tf_pkg::tf_stage_t data,
    output logic              valid_q,
    output tf_pkg::tf_stage_t data_q
);
    import tf_pkg::*;

    logic      valid_reg;
    tf_stage_t data_reg;
    tf_stage_t data_next;

    always_comb
    begin
        data_next   = data;
        data_next.a = data.a + data.b;
        data_next.b = rotl32(data.b, ROT) ^ data_next.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_q = valid_reg;
    assign data_q  = data_reg;

endmodule

// ===== hw/rtl/tf_inject.sv =====
// Key injection after a group of four rounds, as a pipeline register stage.
// Depends on tf_pkg.
module tf_inject #(
    parameter int unsigned GROUP = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  tf_pkg::tf_stage_t data,
    output logic              valid_q,
    output tf_pkg::tf_stage_t data_q
);
    import tf_pkg::*;

    localparam int unsigned IDX_A = GROUP % 3;
    localparam int unsigned IDX_B = (GROUP + 1) % 3;
    localparam logic [WORD_W-1:0] GROUP_WORD = WORD_W'(GROUP);

    logic      valid_reg;
    tf_stage_t data_reg;
    tf_stage_t data_next;

    always_comb
    begin
        data_next   = data;
        data_next.a = data.a + data.kw[IDX_A];
        data_next.b = data.b + data.kw[IDX_B] + GROUP_WORD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_q = valid_reg;
    assign data_q  = data_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the Threefry-2x32-20 generator: known-answer and corner requests,
// then random and batch-style requests under changing idle and stall patterns.
// Depends on tf_pkg, tf_if and the generator RTL.
module tb_top;
    import tf_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t key_lo;
        word_t key_hi;
        word_t count_lo;
        word_t count_hi;
        logic  last;
    } request_t;

    typedef struct packed {
        word_t lo;
        word_t hi;
        logic  last;
    } rand_pair_t;

    typedef struct packed {
        request_t   req;
        logic       known;
        rand_pair_t want;
    } directed_row_t;

    localparam word_t KEY_PARITY = 32'h1BD1_1BDA;
    // Groups 1, 3 and 5 use the first set, groups 2 and 4 the second.
    localparam logic [0:3][4:0] ROT_SET_A = {5'd13, 5'd15, 5'd26, 5'd6};
    localparam logic [0:3][4:0] ROT_SET_B = {5'd17, 5'd29, 5'd16, 5'd24};

    localparam int QUIET_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PER_PLAN = 175;
    localparam int N_DIRECTED      = 13;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
          '{32'h6b20_0159, 32'h99ba_4efe, 1'b0}},
        '{'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1,
          '{32'h1cb9_96fc, 32'hbb00_2be7, 1'b1}},
        '{'{32'h1319_8a2e, 32'h0370_7344, 32'h243f_6a88, 32'h85a3_08d3, 1'b0}, 1'b1,
          '{32'hc492_3a9c, 32'h483d_f7a0, 1'b0}},
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
          '{32'h6b20_0159, 32'h99ba_4efe, 1'b1}},
        '{'{32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 1'b1}, 1'b0, '0},
        '{'{32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 1'b0}, 1'b0, '0},
        '{'{32'h1bd1_1bda, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b0, '0},
        '{'{32'hdead_beef, 32'h1234_5678, 32'hffff_fffe, 32'hffff_fffe, 1'b0}, 1'b0, '0}
    };

    localparam int IDLE_PLAN  [4] = '{0, 76, 0, 34};
    localparam int STALL_PLAN [4] = '{0, 0, 76, 34};

    logic clk = 1'b0;
    logic rst_n;

    tf_in_if  cnt_ch ();
    tf_out_if rnd_ch ();

    threefry2x32_20_round_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cnt   (cnt_ch),
        .rnd   (rnd_ch)
    );

    rand_pair_t expected_words [$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rand_pair_t threefry_words(input request_t r);
        word_t      ks [3];
        word_t      x0;
        word_t      x1;
        logic [63:0] spun;
        logic [4:0] rot_amt;
        rand_pair_t res;
        begin
            ks[0] = r.key_lo;
            ks[1] = r.key_hi;
            ks[2] = r.key_lo ^ r.key_hi ^ KEY_PARITY;
            x0 = r.count_lo + ks[0];
            x1 = r.count_hi + ks[1];
            for (int grp = 1; grp <= 5; grp++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rot_amt = (grp % 2 == 1) ? ROT_SET_A[i] : ROT_SET_B[i];
                    x0      = x0 + x1;
                    // The upper half of the doubled word shifted left is the rotation.
                    spun = {x1, x1} << rot_amt;
                    x1   = spun[63:32] ^ x0;
                end
                x0 = x0 + ks[grp % 3];
                x1 = x1 + ks[(grp + 1) % 3] + word_t'(grp);
            end
            res.lo   = x0;
            res.hi   = x1;
            res.last = r.last;
            return res;
        end
    endfunction

    function automatic word_t edge_word();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("tb_top: mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Holds the request on the channel until it is taken, then queues its result.
    task automatic send_request(input request_t r, input logic known, input rand_pair_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cnt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cnt_ch.valid    <= 1'b1;
        cnt_ch.key_lo   <= r.key_lo;
        cnt_ch.key_hi   <= r.key_hi;
        cnt_ch.count_lo <= r.count_lo;
        cnt_ch.count_hi <= r.count_hi;
        cnt_ch.last_in  <= r.last;
        @(posedge clk);
        while (!cnt_ch.ready)
            @(posedge clk);
        expected_words.push_back(known ? want : threefry_words(r));
    endtask

    always @(posedge clk)
    begin : result_check
        rand_pair_t want;
        if (rst_n && rnd_ch.valid && rnd_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected result, rand_lo", rnd_ch.rand_lo, '0);
            else
            begin
                want = expected_words.pop_front();
                if (rnd_ch.rand_lo !== want.lo)
                    report_mismatch("rand_lo", rnd_ch.rand_lo, want.lo);
                if (rnd_ch.rand_hi !== want.hi)
                    report_mismatch("rand_hi", rnd_ch.rand_hi, want.hi);
                if (rnd_ch.last_out !== want.last)
                    report_mismatch("last_out", word_t'(rnd_ch.last_out), word_t'(want.last));
            end
        end
        rnd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cnt_ch.valid && cnt_ch.ready) || (rnd_ch.valid && rnd_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        request_t    req;
        word_t       batch_key_lo;
        word_t       batch_key_hi;
        logic [63:0] batch_count;
        int          batch_left;
        int          pick;

        batch_key_lo    = '0;
        batch_key_hi    = '0;
        batch_count     = '0;
        batch_left      = 0;
        rst_n           = 1'b0;
        cnt_ch.valid    = 1'b0;
        cnt_ch.key_lo   = '0;
        cnt_ch.key_hi   = '0;
        cnt_ch.count_lo = '0;
        cnt_ch.count_hi = '0;
        cnt_ch.last_in  = 1'b0;
        rnd_ch.ready    = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

        for (int plan = 0; plan < 4; plan++)
        begin
            send_idle_pct  = IDLE_PLAN[plan];
            recv_stall_pct = STALL_PLAN[plan];
            repeat (RANDOM_PER_PLAN)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    req.key_lo   = $urandom;
                    req.key_hi   = $urandom;
                    req.count_lo = $urandom;
                    req.count_hi = $urandom;
                    req.last     = 1'($urandom_range(1));
                end
                else if (pick < 80)
                begin
                    // A batch: one key, consecutive 64-bit counters, last on the final element.
                    if (batch_left == 0)
                    begin
                        batch_key_lo = $urandom;
                        batch_key_hi = $urandom;
                        batch_count  = {edge_word(), edge_word()};
                        batch_left   = $urandom_range(16, 1);
                    end
                    req.key_lo   = batch_key_lo;
                    req.key_hi   = batch_key_hi;
                    req.count_lo = batch_count[31:0];
                    req.count_hi = batch_count[63:32];
                    req.last     = (batch_left == 1);
                    batch_count  = batch_count + 64'd1;
                    batch_left--;
                end
                else
                begin
                    req.key_lo   = edge_word();
                    req.key_hi   = edge_word();
                    req.count_lo = edge_word();
                    req.count_hi = edge_word();
                    req.last     = 1'($urandom_range(1));
                end
                send_request(req, 1'b0, '0);
            end
        end

        cnt_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
